@@ rtl/mna_pkg.sv @@
// Shared types, widths and codes for the mixed number ALU.
package mna_pkg;

   localparam int IN_WIDTH_DEF = 16;
   localparam int WHOLE_W      = 16;
   localparam int DEN_W        = 15;
   localparam int RES_WHOLE_W  = 62;
   localparam int RES_FRAC_W   = 47;
   localparam int OP_W         = 33;   // improper fraction and multiplier operand
   localparam int NUM_W        = 62;   // signed products and sums
   localparam int MAG_W        = 62;   // unsigned magnitudes in gcd and divider

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_CMP = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INTEGRAL = 2'd1,
      ST_DIVZERO  = 2'd2,
      ST_ZERONUM  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_CMB,
      S_GCD,
      S_DIV_N,
      S_DIV_D,
      S_DIV_Q,
      S_DONE
   } state_type;

endpackage

@@ rtl/mna_if.sv @@
// Request and response channel interfaces.
interface mna_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       action;
   logic signed [mna_pkg::WHOLE_W-1:0] a_whole;
   logic signed [mna_pkg::WHOLE_W-1:0] a_num;
   logic [mna_pkg::DEN_W-1:0]        a_den;
   logic signed [mna_pkg::WHOLE_W-1:0] b_whole;
   logic signed [mna_pkg::WHOLE_W-1:0] b_num;
   logic [mna_pkg::DEN_W-1:0]        b_den;
   modport source (output valid, action, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   input ready);
   modport sink   (input valid, action, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   output ready);
endinterface

interface mna_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mna_pkg::RES_WHOLE_W-1:0] res_whole;
   logic signed [mna_pkg::RES_FRAC_W-1:0]  res_num;
   logic signed [mna_pkg::RES_FRAC_W-1:0]  res_den;
   logic [1:0]                            status;
   modport source (output valid, res_whole, res_num, res_den, status, input ready);
   modport sink   (input valid, res_whole, res_num, res_den, status, output ready);
endinterface

@@ rtl/mna_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module mna_divider #(
   parameter int W = mna_pkg::MAG_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start && !busy_ff) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;
endmodule

@@ rtl/mixed_number_alu.sv @@
// Top level: mixed number ALU with gcd reduction on a shared multiplier and divider.
//  channel   dir  handshake        payload
//  req_ch    in   valid / ready    action, a_whole, a_num, a_den, b_whole, b_num, b_den
//  rsp_ch    out  valid / ready    res_whole, res_num, res_den, status
// An item passes through accept, six multiplies, combine, the binary gcd steps, three divisions
// (numerator and denominator by the gcd, then numerator by denominator) and hand-off.
// Compare skips the gcd and does one division; the zero cases finish after combining.
// Six multiplies share one 33x33 multiplier, one per cycle.
// Reset is synchronous and clears the sequencer and the response valid.
// The next item is taken once the sequencer is idle and the response register is free
// or being read; a stalled response holds.
module mixed_number_alu #(
   parameter int IN_WIDTH = mna_pkg::IN_WIDTH_DEF
) (
   input logic    clock,
   input logic    reset,
   mna_req_if.sink   req_ch,
   mna_rsp_if.source rsp_ch
);
   localparam int OW = mna_pkg::OP_W;
   localparam int NW = mna_pkg::NUM_W;
   localparam int MW = mna_pkg::MAG_W;
   localparam int KW = $clog2(MW);

   mna_pkg::state_type state_ff, state_in;

   logic [2:0]           act_ff, act_in;
   logic signed [OW-1:0] aw_ff, an_ff, ad_ff, bw_ff, bn_ff, bd_ff;
   logic signed [OW-1:0] aw_in, an_in, ad_in, bw_in, bn_in, bd_in;
   logic signed [OW-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic signed [NW-1:0] x1_ff, x1_in, x2_ff, x2_in, x3_ff, x3_in, x4_ff, x4_in;
   logic [2:0]           step_ff, step_in;
   logic [MW-1:0]        ga_ff, ga_in, gb_ff, gb_in;
   logic [KW-1:0]        gk_ff, gk_in;
   logic [MW-1:0]        nmag_ff, nmag_in, dmag_ff, dmag_in;
   logic                 sn_ff, sn_in, sd_ff, sd_in;
   logic                 issued_ff, issued_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [mna_pkg::RES_WHOLE_W-1:0] res_whole_ff, res_whole_in;
   logic signed [mna_pkg::RES_FRAC_W-1:0]  res_num_ff, res_num_in;
   logic signed [mna_pkg::RES_FRAC_W-1:0]  res_den_ff, res_den_in;
   logic [1:0]                   status_ff, status_in;

   logic signed [OW-1:0]   mul_a, mul_b;
   logic signed [2*OW-1:0] prod;
   logic signed [NW-1:0]   n_c, d_c;
   logic                   out_free;
   logic                   div_start, div_done;
   logic [MW-1:0]          div_dvd, div_dvs, div_q, div_r;
   logic [MW-1:0]          q_s, r_s;

   function automatic logic [MW-1:0] magn(input logic signed [NW-1:0] v);
      magn = v[NW-1] ? MW'(-v) : MW'(v);
   endfunction

   mna_divider #(.W(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   always_comb begin
      unique case (step_ff)
         3'd0:    begin mul_a = aw_ff; mul_b = ad_ff; end
         3'd1:    begin mul_a = bw_ff; mul_b = bd_ff; end
         3'd2:    begin mul_a = fa_ff; mul_b = bd_ff; end
         3'd3:    begin mul_a = fb_ff; mul_b = ad_ff; end
         3'd4:    begin mul_a = fa_ff; mul_b = fb_ff; end
         default: begin mul_a = ad_ff; mul_b = bd_ff; end
      endcase
      prod = mul_a * mul_b;
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign q_s = (sn_ff ^ sd_ff) ? -div_q : div_q;
   assign r_s = sn_ff ? -div_r : div_r;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      aw_in = aw_ff; an_in = an_ff; ad_in = ad_ff;
      bw_in = bw_ff; bn_in = bn_ff; bd_in = bd_ff;
      fa_in = fa_ff; fb_in = fb_ff;
      x1_in = x1_ff; x2_in = x2_ff; x3_in = x3_ff; x4_in = x4_ff;
      step_in      = step_ff;
      ga_in = ga_ff; gb_in = gb_ff; gk_in = gk_ff;
      nmag_in = nmag_ff; dmag_in = dmag_ff;
      sn_in = sn_ff; sd_in = sd_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      res_whole_in = res_whole_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      div_dvd      = nmag_ff;
      div_dvs      = dmag_ff;
      n_c          = '0;
      d_c          = '0;
      // hold the input while busy, or while an earlier result still waits in the response register
      req_ch.ready = (state_ff == mna_pkg::S_IDLE) && out_free;

      unique case (state_ff)
         mna_pkg::S_IDLE: begin
            if (req_ch.valid && out_free) begin
               act_in = req_ch.action;
               aw_in = OW'(signed'(req_ch.a_whole[IN_WIDTH-1:0]));
               an_in = OW'(signed'(req_ch.a_num[IN_WIDTH-1:0]));
               ad_in = OW'(req_ch.a_den[IN_WIDTH-2:0]);
               bw_in = OW'(signed'(req_ch.b_whole[IN_WIDTH-1:0]));
               bn_in = OW'(signed'(req_ch.b_num[IN_WIDTH-1:0]));
               bd_in = OW'(req_ch.b_den[IN_WIDTH-2:0]);
               step_in  = 3'd0;
               state_in = mna_pkg::S_MUL;
            end
         end
         mna_pkg::S_MUL: begin
            case (step_ff)
               3'd0:    fa_in = prod[OW-1:0] + an_ff;
               3'd1:    fb_in = prod[OW-1:0] + bn_ff;
               3'd2:    x1_in = prod[NW-1:0];
               3'd3:    x2_in = prod[NW-1:0];
               3'd4:    x3_in = prod[NW-1:0];
               default: x4_in = prod[NW-1:0];
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) state_in = mna_pkg::S_CMB;
         end
         mna_pkg::S_CMB: begin
            case (act_ff)
               mna_pkg::ACT_ADD: begin n_c = x1_ff + x2_ff; d_c = x4_ff; end
               mna_pkg::ACT_SUB: begin n_c = x1_ff - x2_ff; d_c = x4_ff; end
               mna_pkg::ACT_MUL: begin n_c = x3_ff;         d_c = x4_ff; end
               mna_pkg::ACT_DIV: begin n_c = x1_ff;         d_c = x2_ff; end
               default: begin
                  // take A only when strictly larger
                  if (x1_ff > x2_ff) begin
                     n_c = NW'(fa_ff); d_c = NW'(ad_ff);
                  end else begin
                     n_c = NW'(fb_ff); d_c = NW'(bd_ff);
                  end
               end
            endcase
            sn_in   = n_c[NW-1];
            sd_in   = d_c[NW-1];
            nmag_in = magn(n_c);
            dmag_in = magn(d_c);
            ga_in   = magn(n_c);
            gb_in   = magn(d_c);
            gk_in   = '0;
            if (d_c == '0) begin
               status_in = mna_pkg::ST_DIVZERO;
               res_whole_in = '0; res_num_in = '0; res_den_in = '0;
               state_in = mna_pkg::S_DONE;
            end else if (act_ff > 3'(mna_pkg::ACT_DIV)) begin
               state_in = mna_pkg::S_DIV_Q;
            end else if (n_c == '0) begin
               status_in = mna_pkg::ST_ZERONUM;
               res_whole_in = '0; res_num_in = '0;
               res_den_in = mna_pkg::RES_FRAC_W'(1);
               state_in = mna_pkg::S_DONE;
            end else begin
               state_in = mna_pkg::S_GCD;
            end
         end
         mna_pkg::S_GCD: begin
            // binary gcd: strip common twos, then subtract the smaller odd value
            if (ga_ff == '0) begin
               gb_in    = gb_ff << gk_ff;
               state_in = mna_pkg::S_DIV_N;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + KW'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         mna_pkg::S_DIV_N, mna_pkg::S_DIV_D: begin
            div_dvd = (state_ff == mna_pkg::S_DIV_N) ? nmag_ff : dmag_ff;
            div_dvs = gb_ff;
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               if (state_ff == mna_pkg::S_DIV_N) begin
                  nmag_in  = div_q;
                  state_in = mna_pkg::S_DIV_D;
               end else begin
                  dmag_in  = div_q;
                  state_in = mna_pkg::S_DIV_Q;
               end
            end
         end
         mna_pkg::S_DIV_Q: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in    = 1'b0;
               res_whole_in = mna_pkg::RES_WHOLE_W'(q_s);
               if (div_r == '0) begin
                  status_in  = mna_pkg::ST_INTEGRAL;
                  res_num_in = '0;
                  res_den_in = mna_pkg::RES_FRAC_W'(1);
               end else begin
                  status_in  = mna_pkg::ST_OK;
                  res_num_in = mna_pkg::RES_FRAC_W'(r_s);
                  res_den_in = sd_ff ? mna_pkg::RES_FRAC_W'(-dmag_ff)
                                     : mna_pkg::RES_FRAC_W'(dmag_ff);
               end
               state_in = mna_pkg::S_DONE;
            end
         end
         mna_pkg::S_DONE: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = mna_pkg::S_IDLE;
            end
         end
         default: state_in = mna_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mna_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         issued_ff    <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff    <= issued_in;
         step_ff      <= step_in;
      end
      act_ff <= act_in;
      aw_ff <= aw_in; an_ff <= an_in; ad_ff <= ad_in;
      bw_ff <= bw_in; bn_ff <= bn_in; bd_ff <= bd_in;
      fa_ff <= fa_in; fb_ff <= fb_in;
      x1_ff <= x1_in; x2_ff <= x2_in; x3_ff <= x3_in; x4_ff <= x4_in;
      ga_ff <= ga_in; gb_ff <= gb_in; gk_ff <= gk_in;
      nmag_ff <= nmag_in; dmag_ff <= dmag_in;
      sn_ff <= sn_in; sd_ff <= sd_in;
      res_whole_ff <= res_whole_in;
      res_num_ff   <= res_num_in;
      res_den_ff   <= res_den_in;
      status_ff    <= status_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.res_whole = res_whole_ff;
   assign rsp_ch.res_num   = res_num_ff;
   assign rsp_ch.res_den   = res_den_ff;
   assign rsp_ch.status    = status_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("accepted a second item while busy");

   a_divzero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mna_pkg::ST_DIVZERO |-> res_den_ff == '0)
      else $error("divide by zero with nonzero denominator");

   a_integral_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mna_pkg::ST_INTEGRAL |->
         res_num_ff == '0 && res_den_ff == mna_pkg::RES_FRAC_W'(1))
      else $error("integral result not in whole form");

   a_ok_has_remainder: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mna_pkg::ST_OK |-> res_num_ff != '0)
      else $error("ok status with zero remainder");
endmodule

@@ sim/mixed_number_alu_test.sv @@
// Self-checking testbench for the mixed number ALU: directed and random operand items.
module mixed_number_alu_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int RANDOM_ITEMS   = 1630;

   typedef struct {
      logic [2:0]         action;
      logic signed [15:0] a_whole;
      logic signed [15:0] a_num;
      logic [14:0]        a_den;
      logic signed [15:0] b_whole;
      logic signed [15:0] b_num;
      logic [14:0]        b_den;
   } operand_type;

   typedef struct {
      logic signed [mna_pkg::RES_WHOLE_W-1:0] whole;
      logic signed [mna_pkg::RES_FRAC_W-1:0]  num;
      logic signed [mna_pkg::RES_FRAC_W-1:0]  den;
      mna_pkg::status_type                    status;
   } result_type;

   class ledger_type;
      result_type expected_results[$];
      int         mismatches = 0;
      int         checked = 0;
      int         status_seen[4] = '{0, 0, 0, 0};

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      function result_type split_fraction(longint n, longint d);
         result_type r;
         longint q, m;
         q = n / d;
         m = n % d;
         r.whole = mna_pkg::RES_WHOLE_W'(q);
         if (m == 0) begin
            r.num = '0; r.den = mna_pkg::RES_FRAC_W'(1); r.status = mna_pkg::ST_INTEGRAL;
         end else begin
            r.num = mna_pkg::RES_FRAC_W'(m);
            r.den = mna_pkg::RES_FRAC_W'(d);
            r.status = mna_pkg::ST_OK;
         end
         return r;
      endfunction

      function result_type predict_fraction(operand_type it);
         result_type r;
         longint fa, fb, ad, bd, n, d;
         longint unsigned x, y, t;
         ad = it.a_den;
         bd = it.b_den;
         fa = longint'(it.a_whole) * ad + longint'(it.a_num);
         fb = longint'(it.b_whole) * bd + longint'(it.b_num);
         r.whole = '0; r.num = '0; r.den = '0; r.status = mna_pkg::ST_DIVZERO;
         if (it.action > mna_pkg::ACT_DIV) begin
            // larger operand wins, B on a tie
            if (fa * bd > fb * ad) begin
               n = fa; d = ad;
            end else begin
               n = fb; d = bd;
            end
            if (d != 0) r = split_fraction(n, d);
            return r;
         end
         case (it.action)
            mna_pkg::ACT_ADD: begin n = fa * bd + fb * ad; d = ad * bd; end
            mna_pkg::ACT_SUB: begin n = fa * bd - fb * ad; d = ad * bd; end
            mna_pkg::ACT_MUL: begin n = fa * fb; d = ad * bd; end
            default: begin n = fa * bd; d = ad * fb; end
         endcase
         if (d == 0) return r;
         if (n == 0) begin
            r.den = mna_pkg::RES_FRAC_W'(1); r.status = mna_pkg::ST_ZERONUM;
            return r;
         end
         x = (n < 0) ? -n : n;
         y = (d < 0) ? -d : d;
         while (y != 0) begin
            t = x % y; x = y; y = t;
         end
         n = n / longint'(x);
         d = d / longint'(x);
         return split_fraction(n, d);
      endfunction

      function void note_operands(operand_type it);
         expected_results.push_back(predict_fraction(it));
      endfunction

      task check_result(result_type got);
         result_type exp;
         if (expected_results.size() == 0) begin
            report("result with nothing expected");
            return;
         end
         exp = expected_results.pop_front();
         checked++;
         status_seen[exp.status]++;
         if (got.whole !== exp.whole)
            report($sformatf("res_whole %0d, expected %0d", got.whole, exp.whole));
         if (got.num !== exp.num)
            report($sformatf("res_num %0d, expected %0d", got.num, exp.num));
         if (got.den !== exp.den)
            report($sformatf("res_den %0d, expected %0d", got.den, exp.den));
         if (got.status !== exp.status)
            report($sformatf("status %0d, expected %0d", got.status, exp.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mna_req_if req_ch ();
   mna_rsp_if rsp_ch ();

   mixed_number_alu i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   ledger_type ledger = new();
   int send_idle = 14;
   int recv_idle = 56;
   int hold_request = 0;
   int quiet_cycles = 0;
   int sent_items = 0;

   always #4 clock = ~clock;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.action  = mna_pkg::ACT_ADD;
      req_ch.a_whole = '0;
      req_ch.a_num   = '0;
      req_ch.a_den   = 15'd1;
      req_ch.b_whole = '0;
      req_ch.b_num   = '0;
      req_ch.b_den   = 15'd1;
      rsp_ch.ready   = 1'b0;
   end

   // monitor both channels on the clock edge
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            operand_type it;
            it.action = req_ch.action;
            it.a_whole = req_ch.a_whole; it.a_num = req_ch.a_num; it.a_den = req_ch.a_den;
            it.b_whole = req_ch.b_whole; it.b_num = req_ch.b_num; it.b_den = req_ch.b_den;
            ledger.note_operands(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.whole = rsp_ch.res_whole;
            got.num = rsp_ch.res_num;
            got.den = rsp_ch.res_den;
            got.status = mna_pkg::status_type'(rsp_ch.status);
            ledger.check_result(got);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         hold_left = 0;
      end else if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
                  ledger.expected_results.size());
         $display("mixed_number_alu verification failed");
         $finish;
      end
   end

   task send_item(operand_type it);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= it.action;
      req_ch.a_whole <= it.a_whole;
      req_ch.a_num   <= it.a_num;
      req_ch.a_den   <= it.a_den;
      req_ch.b_whole <= it.b_whole;
      req_ch.b_num   <= it.b_num;
      req_ch.b_den   <= it.b_den;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   task send_fields(int act, int aw, int an, int ad, int bw, int bn, int bd);
      operand_type it;
      it.action = 3'(act);
      it.a_whole = 16'(aw); it.a_num = 16'(an); it.a_den = 15'(ad);
      it.b_whole = 16'(bw); it.b_num = 16'(bn); it.b_den = 15'(bd);
      send_item(it);
   endtask

   function logic [15:0] pick_signed();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return 16'($signed($urandom_range(40)) - 20);
      if (sel < 6) return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
      return 16'($urandom);
   endfunction

   function logic [14:0] pick_den();
      int sel;
      sel = $urandom_range(99);
      if (sel < 4) return 15'd0;
      if (sel < 60) return 15'($urandom_range(1, 12));
      if (sel < 65) return 15'h7fff;
      return 15'($urandom);
   endfunction

   task send_random();
      operand_type it;
      it.action = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      it.a_whole = pick_signed(); it.a_num = pick_signed(); it.a_den = pick_den();
      it.b_whole = pick_signed(); it.b_num = pick_signed(); it.b_den = pick_den();
      // make some B operands zero to reach divide by zero on a live divisor
      if ($urandom_range(29) == 0) begin
         it.b_whole = '0; it.b_num = '0;
      end
      send_item(it);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every action, extremes and special cases
      send_fields(mna_pkg::ACT_ADD, 1, 1, 2, 2, 1, 3);
      send_fields(mna_pkg::ACT_SUB, 3, 1, 4, 1, 2, 5);
      send_fields(mna_pkg::ACT_MUL, -2, 1, 3, 4, -3, 7);
      send_fields(mna_pkg::ACT_DIV, 5, 2, 9, 1, 1, 6);
      send_fields(mna_pkg::ACT_CMP, 1, 1, 3, 1, 1, 2);
      send_fields(mna_pkg::ACT_CMP, 1, 1, 2, 1, 2, 4);
      send_fields(mna_pkg::ACT_ADD, 0, 1, 2, 0, 1, 2);
      send_fields(mna_pkg::ACT_SUB, 2, 3, 7, 2, 3, 7);
      send_fields(mna_pkg::ACT_ADD, 1, 1, 0, 1, 1, 3);
      send_fields(mna_pkg::ACT_DIV, 1, 1, 3, 0, 0, 5);
      send_fields(mna_pkg::ACT_CMP, 1, 1, 0, 5, 0, 0);
      send_fields(mna_pkg::ACT_CMP, 0, 0, 4, 0, 0, 9);
      send_fields(mna_pkg::ACT_DIV, 3, 0, 5, -2, 1, 3);
      send_fields(5, 1, 2, 3, 4, 5, 6);
      send_fields(6, -7, 3, 8, 2, -1, 5);
      send_fields(7, 0, 1, 1, 0, 1, 1);
      send_fields(mna_pkg::ACT_MUL, 32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(mna_pkg::ACT_MUL, -32768, -32768, 32767, -32768, -32768, 32767);
      send_fields(mna_pkg::ACT_ADD, 32767, 32767, 1, 32767, 32767, 1);
      send_fields(mna_pkg::ACT_SUB, -32768, -32768, 32767, 32767, 32767, 32767);
      send_fields(mna_pkg::ACT_DIV, -32768, -32768, 32767, 0, 1, 32767);
      send_fields(mna_pkg::ACT_CMP, -32768, 32767, 32767, 32767, -32768, 1);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) begin
            send_idle = 56; recv_idle = 14;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            send_idle = 0; recv_idle = 0;
            hold_request = HOLD_CYCLES;
         end
         send_random();
      end
      req_ch.valid <= 1'b0;

      while (ledger.expected_results.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      $display("sent %0d items, checked %0d results (ok %0d, integral %0d, div0 %0d, zero %0d)",
               sent_items, ledger.checked, ledger.status_seen[0], ledger.status_seen[1],
               ledger.status_seen[2], ledger.status_seen[3]);
      $display("idle mixes covered, with a long response hold-off; %0d mismatches",
               ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.expected_results.size() == 0)
         $display("mixed_number_alu verification clean");
      else
         $display("mixed_number_alu verification failed");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/mna_pkg.sv
rtl/mna_if.sv
rtl/mna_divider.sv
rtl/mixed_number_alu.sv
sim/mixed_number_alu_test.sv
